// ===== design/setc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setc_pkg
// Shared types and constants of the scope edge trigger capture block.
// ----------------------------------------------------------------------------
package setc_pkg;

    localparam int RING_DEPTH_DEF = 2048;
    localparam int WINDOW_DEF     = 128;

    localparam int SMP_W     = 12;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 12;

    localparam logic [SMP_W-1:0] LEVEL_RESET = 12'd2047;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LEVEL   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_FALLING = 1'd1;

    // input item modes
    localparam logic MODE_SAMPLE  = 1'b0;
    localparam logic MODE_CAPTURE = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic wr_sample;
        logic srch_init;
        logic srch_prime;
        logic srch_step;
        logic emit_init;
        logic found;
        logic emit_rd0;
        logic emit_rd1;
        logic emit_lat;
        logic out_xfer;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic k_last;
        logic last;
    } t_status;

endpackage

// ===== design/setc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module setc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/setc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setc_ctrl
// Sequencer: sample writes, backward edge search, window readout.
// ----------------------------------------------------------------------------
module setc_ctrl
    import setc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_mode,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_INIT   = 4'd1;
    localparam logic [3:0] S_PRIME  = 4'd2;
    localparam logic [3:0] S_SEARCH = 4'd3;
    localparam logic [3:0] S_EINIT  = 4'd4;
    localparam logic [3:0] S_RD0    = 4'd5;
    localparam logic [3:0] S_RD1    = 4'd6;
    localparam logic [3:0] S_LAT    = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_found, n_found;
    logic       accept;

    assign accept = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_found = r_found;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_mode == MODE_CAPTURE) begin
                        n_state = S_INIT;
                    end else begin
                        o_cmd.wr_sample = 1'b1;
                    end
                end
            end
            S_INIT: begin
                o_cmd.srch_init = 1'b1;
                n_state         = S_PRIME;
            end
            S_PRIME: begin
                o_cmd.srch_prime = 1'b1;
                n_state          = S_SEARCH;
            end
            S_SEARCH: begin
                if (i_status.hit) begin
                    n_found = 1'b1;
                    n_state = S_EINIT;
                end else if (i_status.k_last) begin
                    n_found = 1'b0;
                    n_state = S_EINIT;
                end else begin
                    o_cmd.srch_step = 1'b1;
                end
            end
            S_EINIT: begin
                o_cmd.emit_init = 1'b1;
                o_cmd.found     = r_found;
                n_state         = S_RD0;
            end
            S_RD0: begin
                o_cmd.emit_rd0 = 1'b1;
                n_state        = S_RD1;
            end
            S_RD1: begin
                o_cmd.emit_rd1 = 1'b1;
                n_state        = S_LAT;
            end
            S_LAT: begin
                o_cmd.emit_lat = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                // hold the result until the transfer
                if (i_out_ready) begin
                    o_cmd.out_xfer = 1'b1;
                    n_state        = i_status.last ? S_IDLE : S_RD0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_found <= n_found;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

endmodule

// ===== design/setc_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setc_dpath
// Sample ring, write pointer, fill count, edge test and window readout.
// ----------------------------------------------------------------------------
module setc_dpath
    import setc_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int WINDOW     = WINDOW_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic [SMP_W-1:0]     i_sample,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output logic [SMP_W-1:0]     o_first_sample,
    output logic [SMP_W-1:0]     o_second_sample,
    output logic                 o_trigger_found,
    output logic                 o_last
);

    localparam int IDX_W  = $clog2(RING_DEPTH);
    localparam int FILL_W = IDX_W + 1;
    localparam int K_W    = $clog2(RING_DEPTH / 2);
    localparam int POS_W  = $clog2(WINDOW + 2);

    localparam logic [IDX_W-1:0]  HALF_WIN  = IDX_W'(WINDOW / 2);
    localparam logic [IDX_W-1:0]  WRAP_ADD  = IDX_W'(RING_DEPTH - WINDOW / 2);
    localparam logic [IDX_W-1:0]  TOP_IDX   = IDX_W'(RING_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RING_DEPTH);
    localparam logic [K_W-1:0]    K_LAST    = K_W'(RING_DEPTH / 2 - 1);
    localparam logic [POS_W:0]    WIN_P     = (POS_W + 1)'(WINDOW);

    function automatic logic [IDX_W-1:0] back_half(input logic [IDX_W-1:0] a);
        return (a >= HALF_WIN) ? a - HALF_WIN : a + WRAP_ADD;
    endfunction

    function automatic logic [IDX_W-1:0] dec_idx(input logic [IDX_W-1:0] a);
        return (a == '0) ? TOP_IDX : a - 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] a);
        return (a == TOP_IDX) ? '0 : a + 1'b1;
    endfunction

    logic [IDX_W-1:0]  r_newest;
    logic [FILL_W-1:0] r_fill;
    logic [SMP_W-1:0]  r_level;
    logic              r_falling;

    logic [IDX_W-1:0]  r_addr;
    logic [IDX_W-1:0]  r_ptr;
    logic [IDX_W-1:0]  r_x;
    logic [K_W-1:0]    r_k;
    logic [SMP_W-1:0]  r_cur;
    logic              r_rd_ok;
    logic [POS_W-1:0]  r_pos;

    logic [SMP_W-1:0]  r_first;
    logic [SMP_W-1:0]  r_second;
    logic              r_found;
    logic              r_last;

    logic [IDX_W-1:0]  newest_inc;
    logic [IDX_W-1:0]  start_c;
    logic [IDX_W-1:0]  raddr;
    logic [SMP_W-1:0]  ram_q;
    logic [SMP_W-1:0]  rdm;
    logic              hit;
    logic [POS_W:0]    pos_ext;

    assign newest_inc = inc_idx(r_newest);
    assign start_c    = back_half(r_newest);
    assign pos_ext    = {1'b0, r_pos};

    always_comb begin
        if (i_cmd.srch_init) begin
            raddr = start_c;
        end else if (i_cmd.emit_rd0 || i_cmd.emit_rd1) begin
            raddr = r_ptr;
        end else begin
            raddr = r_addr;
        end
    end

    setc_ram #(
        .WIDTH (SMP_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_sample),
        .i_waddr (newest_inc),
        .i_wdata (i_sample),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    // slots not yet written since reset read as zero
    assign rdm = r_rd_ok ? ram_q : '0;

    // rdm holds the sample just before r_cur's slot
    always_comb begin
        if (r_falling) begin
            hit = (r_cur <= r_level) && (rdm > r_level);
        end else begin
            hit = (r_cur >= r_level) && (rdm < r_level);
        end
    end

    assign o_status.hit    = hit;
    assign o_status.k_last = (r_k == K_LAST);
    assign o_status.last   = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest  <= TOP_IDX;
            r_fill    <= '0;
            r_level   <= LEVEL_RESET;
            r_falling <= 1'b0;
        end else begin
            if (i_cmd.wr_sample) begin
                r_newest <= newest_inc;
                if (r_fill != FILL_FULL) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TRIG_LEVEL:   r_level   <= i_cfg_data[SMP_W-1:0];
                    CFG_EDGE_FALLING: r_falling <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ok <= (r_fill == FILL_FULL) || ({1'b0, raddr} < r_fill);

        if (i_cmd.srch_init) begin
            r_x    <= start_c;
            r_addr <= dec_idx(start_c);
            r_k    <= '0;
        end
        if (i_cmd.srch_prime) begin
            r_cur  <= rdm;
            r_addr <= dec_idx(r_addr);
        end
        if (i_cmd.srch_step) begin
            // advance one slot back: the previous sample becomes current
            r_cur  <= rdm;
            r_x    <= dec_idx(r_x);
            r_k    <= r_k + 1'b1;
            r_addr <= dec_idx(r_addr);
        end

        if (i_cmd.emit_init) begin
            r_ptr   <= i_cmd.found ? back_half(r_x) : '0;
            r_found <= i_cmd.found;
            r_pos   <= '0;
        end
        if (i_cmd.emit_rd0) begin
            r_ptr <= inc_idx(r_ptr);
        end
        if (i_cmd.emit_rd1) begin
            r_ptr   <= inc_idx(r_ptr);
            r_first <= rdm;
        end
        if (i_cmd.emit_lat) begin
            r_second <= (pos_ext + 1'b1 < WIN_P) ? rdm : '0;
            r_last   <= (pos_ext + 2'd2 >= WIN_P);
        end
        if (i_cmd.out_xfer) begin
            r_pos <= r_pos + 2'd2;
        end
    end

    assign o_first_sample  = r_first;
    assign o_second_sample = r_second;
    assign o_trigger_found = r_found;
    assign o_last          = r_last;

endmodule

// ===== design/scope_edge_trigger_capture.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scope_edge_trigger_capture
// Sample ring with backward edge search and centered window readout (from slot 0 if no edge is found).
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  input     i_in_valid / o_in_ready    i_mode, i_sample
//  output    o_out_valid / i_out_ready  o_first_sample, o_second_sample,
//                                       o_trigger_found, o_last
//  config    i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
//  Samples can stream every cycle while no capture is in progress.
//  A capture item first searches backward after its transfer, testing at most
//  RING_DEPTH/2 slots, and then reads out WINDOW/2 results rounded up, each
//  from two ring reads, all through the single read port of the ring RAM.
//  Input is held off from a capture until its last result is transferred;
//  output stalls simply extend the readout.
//  After reset a fill count makes unwritten slots read as zero.
// ----------------------------------------------------------------------------
module scope_edge_trigger_capture
    import setc_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int WINDOW     = WINDOW_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_mode,
    input  logic [SMP_W-1:0]     i_sample,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [SMP_W-1:0]     o_first_sample,
    output logic [SMP_W-1:0]     o_second_sample,
    output logic                 o_trigger_found,
    output logic                 o_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    setc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_mode),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    setc_dpath #(
        .RING_DEPTH (RING_DEPTH),
        .WINDOW     (WINDOW)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_sample        (i_sample),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_first_sample  (o_first_sample),
        .o_second_sample (o_second_sample),
        .o_trigger_found (o_trigger_found),
        .o_last          (o_last)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    a_capture_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_mode == MODE_CAPTURE)) |=> !o_in_ready)
        else $error("input not held off after capture request");

    a_last_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last) |=> (o_in_ready && !o_out_valid))
        else $error("block not idle after final result");

    a_gap_between: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last) |=> !o_out_valid)
        else $error("result shown before its samples were read");

endmodule

// ===== verif/tb_scope_edge_trigger_capture.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scope_edge_trigger_capture
// Self-checking bench for the scope edge trigger capture block. A local
// mirror of the sample ring and trigger registers predicts every window pair
// of each capture; a monitor compares each output transfer field by field.
// Directed cases cover the empty ring, sample extremes, register extremes and
// a search and a window that wrap past slot 0; random traffic streams
// waveforms around the trigger level under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_scope_edge_trigger_capture;
    import setc_pkg::*;

    localparam int RING_DEPTH  = RING_DEPTH_DEF;
    localparam int WINDOW      = WINDOW_DEF;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 8;

    typedef struct packed {
        logic [SMP_W-1:0] first_smp;
        logic [SMP_W-1:0] second_smp;
        logic             found;
        logic             last;
    } t_window_pair;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_mode;
    logic [SMP_W-1:0]     i_sample;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [SMP_W-1:0]     o_first_sample;
    logic [SMP_W-1:0]     o_second_sample;
    logic                 o_trigger_found;
    logic                 o_last;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    // mirror of the block state
    logic [SMP_W-1:0] ring_mirror [RING_DEPTH];
    int               newest_slot;
    logic [SMP_W-1:0] level_mirror;
    logic             falling_mirror;

    t_window_pair     expected_pairs [$];

    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    int          samples_sent;
    int          captures_sent;
    int          edges_seen;
    int          pairs_checked;
    int          error_count;
    int          cycle_count;

    scope_edge_trigger_capture #(
        .RING_DEPTH (RING_DEPTH),
        .WINDOW     (WINDOW)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_sample        (i_sample),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_first_sample  (o_first_sample),
        .o_second_sample (o_second_sample),
        .o_trigger_found (o_trigger_found),
        .o_last          (o_last),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pairs still pending",
                     cycle_count, expected_pairs.size());
            $display("** scope_edge_trigger_capture: FAILED **");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(99) >= snk_stall_pct);
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        error_count++;
    endtask

    function automatic int wrap_back(input int base, input int back);
        return (base % RING_DEPTH + RING_DEPTH - back % RING_DEPTH) % RING_DEPTH;
    endfunction

    function automatic bit crossing_at(input int slot);
        logic [SMP_W-1:0] cur;
        logic [SMP_W-1:0] prev;
        cur  = ring_mirror[slot];
        prev = ring_mirror[wrap_back(slot, 1)];
        if (falling_mirror)
            return (cur <= level_mirror) && (prev > level_mirror);
        return (cur >= level_mirror) && (prev < level_mirror);
    endfunction

    // search backward for the crossing and queue the centered window
    function automatic void predict_window();
        int           start;
        int           slot;
        int           first;
        int           npairs;
        bit           found;
        t_window_pair pair;
        start = wrap_back(newest_slot, WINDOW / 2);
        slot  = start;
        found = 1'b0;
        for (int k = 0; k < RING_DEPTH / 2 && !found; k++) begin
            slot  = wrap_back(start, k);
            found = crossing_at(slot);
        end
        first  = found ? wrap_back(slot, WINDOW / 2) : 0;
        npairs = (WINDOW + 1) / 2;
        if (found)
            edges_seen++;
        for (int k = 0; k < npairs; k++) begin
            pair.first_smp  = ring_mirror[(first + 2 * k) % RING_DEPTH];
            pair.second_smp = (2 * k + 1 < WINDOW) ?
                              ring_mirror[(first + 2 * k + 1) % RING_DEPTH] : '0;
            pair.found      = found;
            pair.last       = (k == npairs - 1);
            expected_pairs.push_back(pair);
        end
    endfunction

    function automatic void record_item(input logic mode, input logic [SMP_W-1:0] smp);
        if (mode == MODE_SAMPLE) begin
            newest_slot              = (newest_slot + 1) % RING_DEPTH;
            ring_mirror[newest_slot] = smp;
            samples_sent++;
        end else begin
            predict_window();
            captures_sent++;
        end
    endfunction

    task automatic send_item(input logic mode, input logic [SMP_W-1:0] smp);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_mode     = mode;
        i_sample   = smp;
        do @(posedge i_clk); while (!o_in_ready);
        record_item(mode, smp);
    endtask

    // drop valid and hold until every queued pair has come out
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_pairs.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
        wait_drained();
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_TRIG_LEVEL)
            level_mirror = data[SMP_W-1:0];
        else
            falling_mirror = data[0];
    endtask

    always @(posedge i_clk) begin : check_results
        t_window_pair want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_pairs.size() == 0) begin
                report_mismatch($sformatf("unexpected pair %0d/%0d with no capture pending",
                                          o_first_sample, o_second_sample));
            end else begin
                want = expected_pairs.pop_front();
                if (o_first_sample !== want.first_smp)
                    report_mismatch($sformatf("first_sample %0d, want %0d",
                                              o_first_sample, want.first_smp));
                if (o_second_sample !== want.second_smp)
                    report_mismatch($sformatf("second_sample %0d, want %0d",
                                              o_second_sample, want.second_smp));
                if (o_trigger_found !== want.found)
                    report_mismatch($sformatf("trigger_found %0b, want %0b",
                                              o_trigger_found, want.found));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", o_last, want.last));
            end
            pairs_checked++;
        end
    end

    // all-zero ring after reset: no crossing, window of zeros
    task automatic test_empty_ring();
        send_item(MODE_CAPTURE, '0);
    endtask

    // start of ring holds the samples, so the no-crossing window shows them
    task automatic test_sample_extremes();
        send_item(MODE_SAMPLE, 12'd0);
        send_item(MODE_SAMPLE, 12'd4095);
        send_item(MODE_SAMPLE, 12'hAAA);
        send_item(MODE_SAMPLE, 12'h555);
        send_item(MODE_SAMPLE, 12'd2046);
        send_item(MODE_SAMPLE, 12'd2047);
        send_item(MODE_SAMPLE, 12'd2048);
        send_item(MODE_SAMPLE, 12'd1);
        send_item(MODE_SAMPLE, 12'd4094);
        send_item(MODE_CAPTURE, '0);
    endtask

    task automatic test_register_extremes();
        set_register(CFG_TRIG_LEVEL, 12'd0);
        set_register(CFG_EDGE_FALLING, 12'd0);
        send_item(MODE_CAPTURE, '0);
        set_register(CFG_TRIG_LEVEL, 12'd4095);
        set_register(CFG_EDGE_FALLING, 12'd1);
        send_item(MODE_CAPTURE, '0);
        // upper data bits must not reach the one-bit edge select
        set_register(CFG_EDGE_FALLING, 12'hFFE);
        send_item(MODE_CAPTURE, '0);
        set_register(CFG_TRIG_LEVEL, LEVEL_RESET);
    endtask

    // search start wraps below slot 0 into unwritten slots, then a rising
    // edge at slot 1 whose window wraps back into the top of the ring
    task automatic test_ring_wrap();
        src_idle_pct  = 34;
        snk_stall_pct = 34;
        set_register(CFG_TRIG_LEVEL, 12'd2000);
        set_register(CFG_EDGE_FALLING, 12'd1);
        while (newest_slot != 30)
            send_item(MODE_SAMPLE, 12'($urandom_range(4095)));
        send_item(MODE_CAPTURE, '0);
        repeat (40)
            send_item(MODE_SAMPLE, 12'($urandom_range(2000)));
        // rising to full scale: slot 1 holds the only crossing below the start
        set_register(CFG_TRIG_LEVEL, 12'd4095);
        set_register(CFG_EDGE_FALLING, 12'd0);
        send_item(MODE_CAPTURE, '0);
    endtask

    // square waves around the level with noise mixed in, captures now and then
    task automatic test_random_traffic();
        logic [SMP_W-1:0] lvl;
        logic [SMP_W-1:0] smp;
        bit               high_half;
        int               half;
        int               pos;
        for (int chunk = 0; chunk < 8; chunk++) begin
            case (chunk / 2)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 70; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 70; end
                default: begin src_idle_pct = 34; snk_stall_pct = 34; end
            endcase
            case (chunk % 4)
                0: begin
                    set_register(CFG_TRIG_LEVEL, 12'd0);
                    set_register(CFG_EDGE_FALLING, 12'd1);
                end
                1: begin
                    set_register(CFG_TRIG_LEVEL, 12'd4095);
                    set_register(CFG_EDGE_FALLING, 12'd0);
                end
                default: begin
                    set_register(CFG_TRIG_LEVEL, 12'($urandom_range(4095)));
                    set_register(CFG_EDGE_FALLING, 12'($urandom_range(1)));
                end
            endcase
            lvl       = level_mirror;
            half      = $urandom_range(40, 2);
            pos       = 0;
            high_half = 1'b0;
            for (int n = 0; n < 18; n++) begin
                if ($urandom_range(99) < 10) begin
                    send_item(MODE_CAPTURE, 12'($urandom_range(4095)));
                    if ($urandom_range(3) == 0)
                        wait_drained();
                end else if ($urandom_range(99) < 25) begin
                    send_item(MODE_SAMPLE, 12'($urandom_range(4095)));
                end else begin
                    pos++;
                    if (pos >= half) begin
                        pos       = 0;
                        high_half = !high_half;
                    end
                    if (high_half)
                        smp = 12'($urandom_range(4095, lvl));
                    else
                        smp = (lvl == 0) ? 12'd0 : 12'($urandom_range(lvl - 1, 0));
                    send_item(MODE_SAMPLE, smp);
                end
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_mode        = MODE_SAMPLE;
        i_sample      = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_TRIG_LEVEL;
        i_cfg_data    = '0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        foreach (ring_mirror[i])
            ring_mirror[i] = '0;
        newest_slot    = RING_DEPTH - 1;
        level_mirror   = LEVEL_RESET;
        falling_mirror = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_ring();
        test_sample_extremes();
        test_register_extremes();
        test_ring_wrap();
        test_random_traffic();

        wait_drained();
        repeat (20) @(negedge i_clk);

        $display("run covered %0d samples and %0d captures (%0d with an edge found),",
                 samples_sent, captures_sent, edges_seen);
        $display("%0d window pairs checked, %0d mismatches", pairs_checked, error_count);
        if (error_count == 0 && expected_pairs.size() == 0) begin
            $display("** scope_edge_trigger_capture: PASSED **");
        end else begin
            $display("** scope_edge_trigger_capture: FAILED **");
        end
        $finish;
    end

endmodule
